FILE: rtl/assert_macros.svh
// Assertion macros used by the pulse controller core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Check a property on every rising clock edge outside reset
`define STPC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that a condition never holds on a rising clock edge outside reset
`define STPC_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define STPC_ASSERT(lbl, prop, msg)
`define STPC_NEVER(lbl, cond, msg)
`endif

`endif

FILE: rtl/stpc_pkg.sv
// Types and constants of the servo tester pulse controller
package stpc_pkg;

    // Request codes on the action field
    typedef enum logic [2:0] {
        ACT_SHORT  = 3'd0,
        ACT_DOUBLE = 3'd1,
        ACT_LONG   = 3'd2,
        ACT_RIGHT  = 3'd3,
        ACT_LEFT   = 3'd4,
        ACT_TICK   = 3'd5
    } action_t;

    // Sweep direction
    typedef enum logic [1:0] {
        DIR_NONE = 2'd0,
        DIR_FWD  = 2'd1,
        DIR_BWD  = 2'd2
    } dir_t;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_PULSE_MIN    = 3'd0,
        CFG_PULSE_MAX    = 3'd1,
        CFG_PULSE_CENTRE = 3'd2,
        CFG_SWEEP_LOW    = 3'd3,
        CFG_SWEEP_HIGH   = 3'd4,
        CFG_FINE_STEP    = 3'd5,
        CFG_COARSE_UNIT  = 3'd6,
        CFG_STEP_LIMIT   = 3'd7
    } cfg_index_t;

    // Key step holds up to 6 * 65535
    localparam int STEP_W = 19;
    localparam int SUM_W  = STEP_W + 1;

    // Register reset values
    localparam logic [15:0] PULSE_MIN_RST    = 16'd500;
    localparam logic [15:0] PULSE_MAX_RST    = 16'd2500;
    localparam logic [15:0] PULSE_CENTRE_RST = 16'd1500;
    localparam logic [15:0] SWEEP_LOW_RST    = 16'd1000;
    localparam logic [15:0] SWEEP_HIGH_RST   = 16'd2000;
    localparam logic [15:0] FINE_STEP_RST    = 16'd10;
    localparam logic [15:0] COARSE_UNIT_RST  = 16'd40;
    localparam logic [7:0]  STEP_LIMIT_RST   = 8'd100;

    // Period lengths (20, 8, 4, 3 ms) in units of the top scale
    localparam int PERIOD_TAB [4] = '{200, 80, 40, 30};

    // PWM top for one period index, saturated to 16 bits
    function automatic logic [15:0] top_value(input int scale, input int idx);
        int prod;
        prod = scale * PERIOD_TAB[idx];
        if (prod > 65535)
        begin
            return 16'hFFFF;
        end
        return 16'(prod);
    endfunction

endpackage

FILE: rtl/servo_tester_pulse_controller_core.sv
// Servo tester pulse controller: key and sweep-tick requests in, PWM settings out
//
// Usage:
//   Input channel (in_valid/in_ready) carries one request: a key event
//   (short, double, long, right, left) with encoder velocity, or a sweep tick.
//   Output channel (out_valid/out_ready) returns one result per request: the
//   PWM compare and top values and the mode state after that request.
//   Configuration port (cfg_we/cfg_index/cfg_data) writes the pulse and sweep
//   limits; write only while no request is in flight.
// Timing:
//   A request is captured in an input register, then processed into the state
//   registers, which drive the result. One request per cycle is sustained
//   while out_ready stays high; the only loop is the state update through the
//   step adder/compare.
// Reset:
//   Pulse setpoint and compare at 1500, period index 0, pulse mode, sweep off,
//   step 0, operation active; registers at their defaults. No clearing pass.
// Stall:
//   While out_ready is low the held result stays; the input register keeps
//   one more request, and in_ready drops once both are full.
module servo_tester_pulse_controller_core
    import stpc_pkg::*;
#(
    parameter int TOP_SCALE  = 100,
    parameter int SWEEP_UNIT = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    // request channel
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  action,
    input  logic [2:0]  velocity,
    // result channel
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] pulse_compare,
    output logic [15:0] period_top,
    output logic [1:0]  period_select,
    output logic        frequency_mode,
    output logic        sweeping,
    output logic [7:0]  current_sweep_step,
    output logic        active,
    // configuration port
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

`include "assert_macros.svh"

    // PWM top per period index, fixed at elaboration
    localparam logic [15:0] TOP_TAB [4] = '{
        top_value(TOP_SCALE, 0), top_value(TOP_SCALE, 1),
        top_value(TOP_SCALE, 2), top_value(TOP_SCALE, 3)
    };

    // Configuration registers
    logic [15:0] pulse_min_reg;
    logic [15:0] pulse_max_reg;
    logic [15:0] pulse_centre_reg;
    logic [15:0] sweep_low_reg;
    logic [15:0] sweep_high_reg;
    logic [15:0] fine_step_reg;
    logic [15:0] coarse_unit_reg;
    logic [7:0]  step_limit_reg;

    // Input register
    logic        in_valid_reg;
    action_t     action_reg;
    logic [2:0]  velocity_reg;

    // Controller state, which also forms the result register
    logic        out_valid_reg;
    logic [15:0] setpoint_reg,   setpoint_next;
    logic [15:0] compare_reg,    compare_next;
    logic [1:0]  period_reg,     period_next;
    logic        freq_reg,       freq_next;
    logic        sweep_reg,      sweep_next;
    logic [7:0]  step_size_reg,  step_size_next;
    dir_t        dir_reg,        dir_next;
    logic        run_reg,        run_next;

    // Handshake: advance the pipeline when the result slot is free or taken
    logic advance;
    logic take;

    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = !in_valid_reg || advance;
    assign take     = in_valid_reg && advance;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pulse_min_reg    <= PULSE_MIN_RST;
            pulse_max_reg    <= PULSE_MAX_RST;
            pulse_centre_reg <= PULSE_CENTRE_RST;
            sweep_low_reg    <= SWEEP_LOW_RST;
            sweep_high_reg   <= SWEEP_HIGH_RST;
            fine_step_reg    <= FINE_STEP_RST;
            coarse_unit_reg  <= COARSE_UNIT_RST;
            step_limit_reg   <= STEP_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_PULSE_MIN:    pulse_min_reg    <= cfg_data;
                CFG_PULSE_MAX:    pulse_max_reg    <= cfg_data;
                CFG_PULSE_CENTRE: pulse_centre_reg <= cfg_data;
                CFG_SWEEP_LOW:    sweep_low_reg    <= cfg_data;
                CFG_SWEEP_HIGH:   sweep_high_reg   <= cfg_data;
                CFG_FINE_STEP:    fine_step_reg    <= cfg_data;
                CFG_COARSE_UNIT:  coarse_unit_reg  <= cfg_data;
                CFG_STEP_LIMIT:   step_limit_reg   <= cfg_data[7:0];
                default:          ;
            endcase
        end
    end

    // Input register: hold a request until the state update takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            action_reg   <= action_t'(action);
            velocity_reg <= velocity;
        end
    end

    // Key step: velocity 0 or 1 gives the fine step (in sweep, the velocity itself), faster turns scale up
    logic [2:0]        vel_m1;
    logic              vel_big;
    logic [STEP_W-1:0] key_step;

    assign vel_m1  = velocity_reg - 3'd1;
    assign vel_big = velocity_reg > 3'd1;

    always_comb
    begin
        if (sweep_reg)
        begin
            key_step = vel_big ? STEP_W'(vel_m1) * STEP_W'(SWEEP_UNIT)
                               : STEP_W'(velocity_reg);
        end
        else
        begin
            key_step = vel_big ? STEP_W'(vel_m1) * STEP_W'(coarse_unit_reg)
                               : STEP_W'(fine_step_reg);
        end
    end

    // Candidate results of the arithmetic paths
    logic [SUM_W-1:0]  sp_up_sum;
    logic [STEP_W-1:0] sp_down_diff;
    logic [SUM_W-1:0]  ss_up_sum;
    logic [16:0]       tick_up_sum;
    logic [15:0]       tick_down_diff;

    assign sp_up_sum      = SUM_W'(setpoint_reg) + SUM_W'(key_step);
    assign sp_down_diff   = STEP_W'(setpoint_reg) - key_step;
    assign ss_up_sum      = SUM_W'(step_size_reg) + SUM_W'(key_step);
    assign tick_up_sum    = 17'(compare_reg) + 17'(step_size_reg);
    assign tick_down_diff = compare_reg - 16'(step_size_reg);

    // State update for one request
    always_comb
    begin
        setpoint_next  = setpoint_reg;
        compare_next   = compare_reg;
        period_next    = period_reg;
        freq_next      = freq_reg;
        sweep_next     = sweep_reg;
        step_size_next = step_size_reg;
        dir_next       = dir_reg;
        run_next       = run_reg;

        if (take && run_reg)
        begin
            case (action_reg)
                ACT_SHORT:
                begin
                    freq_next = !freq_reg;
                end
                ACT_DOUBLE:
                begin
                    run_next   = 1'b0;
                    sweep_next = 1'b0;
                end
                ACT_LONG:
                begin
                    if (!freq_reg)
                    begin
                        if (sweep_reg)
                        begin
                            step_size_next = 8'd1;
                        end
                        else
                        begin
                            setpoint_next = pulse_centre_reg;
                            compare_next  = pulse_centre_reg;
                        end
                    end
                    else if (sweep_reg)
                    begin
                        sweep_next = 1'b0;
                    end
                    else
                    begin
                        sweep_next     = 1'b1;
                        step_size_next = 8'd1;
                        dir_next       = DIR_FWD;
                    end
                end
                ACT_RIGHT:
                begin
                    if (freq_reg)
                    begin
                        if (period_reg != 2'd3)
                        begin
                            period_next = period_reg + 2'd1;
                        end
                    end
                    else if (sweep_reg)
                    begin
                        // saturate at the step limit
                        if (ss_up_sum > SUM_W'(step_limit_reg))
                        begin
                            step_size_next = step_limit_reg;
                        end
                        else
                        begin
                            step_size_next = ss_up_sum[7:0];
                        end
                    end
                    else
                    begin
                        // clamp to the pulse maximum, also from above it
                        if (sp_up_sum > SUM_W'(pulse_max_reg))
                        begin
                            setpoint_next = pulse_max_reg;
                        end
                        else
                        begin
                            setpoint_next = sp_up_sum[15:0];
                        end
                        compare_next = setpoint_next;
                    end
                end
                ACT_LEFT:
                begin
                    if (freq_reg)
                    begin
                        if (period_reg != 2'd0)
                        begin
                            period_next = period_reg - 2'd1;
                        end
                    end
                    else if (sweep_reg)
                    begin
                        if (key_step >= STEP_W'(step_size_reg))
                        begin
                            step_size_next = 8'd1;
                        end
                        else
                        begin
                            step_size_next = step_size_reg - key_step[7:0];
                        end
                    end
                    else
                    begin
                        // clamp to the pulse minimum, also on underflow
                        if (key_step > STEP_W'(setpoint_reg) ||
                            sp_down_diff < STEP_W'(pulse_min_reg))
                        begin
                            setpoint_next = pulse_min_reg;
                        end
                        else
                        begin
                            setpoint_next = sp_down_diff[15:0];
                        end
                        compare_next = setpoint_next;
                    end
                end
                ACT_TICK:
                begin
                    if (sweep_reg)
                    begin
                        if (dir_reg == DIR_FWD)
                        begin
                            // turn back at the upper bound
                            if (tick_up_sum >= 17'(sweep_high_reg))
                            begin
                                compare_next = sweep_high_reg;
                                dir_next     = DIR_BWD;
                            end
                            else
                            begin
                                compare_next = tick_up_sum[15:0];
                            end
                        end
                        else
                        begin
                            // turn forward at the lower bound
                            if (16'(step_size_reg) >= compare_reg ||
                                tick_down_diff <= sweep_low_reg)
                            begin
                                compare_next = sweep_low_reg;
                                dir_next     = DIR_FWD;
                            end
                            else
                            begin
                                compare_next = tick_down_diff;
                            end
                        end
                    end
                end
                default:
                begin
                    // unknown codes leave the state alone
                end
            endcase
        end
    end

    // State and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            setpoint_reg  <= PULSE_CENTRE_RST;
            compare_reg   <= PULSE_CENTRE_RST;
            period_reg    <= 2'd0;
            freq_reg      <= 1'b0;
            sweep_reg     <= 1'b0;
            step_size_reg <= 8'd0;
            dir_reg       <= DIR_NONE;
            run_reg       <= 1'b1;
        end
        else
        begin
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
            setpoint_reg  <= setpoint_next;
            compare_reg   <= compare_next;
            period_reg    <= period_next;
            freq_reg      <= freq_next;
            sweep_reg     <= sweep_next;
            step_size_reg <= step_size_next;
            dir_reg       <= dir_next;
            run_reg       <= run_next;
        end
    end

    // Result drives straight from the state registers
    assign out_valid          = out_valid_reg;
    assign pulse_compare      = compare_reg;
    assign period_top         = TOP_TAB[period_reg];
    assign period_select      = period_reg;
    assign frequency_mode     = freq_reg;
    assign sweeping           = sweep_reg;
    assign current_sweep_step = step_size_reg;
    assign active             = run_reg;

    // Once stopped, stay stopped
    `STPC_ASSERT(a_run_sticky, !run_reg |=> !run_reg, "run restarted after double press")
    // A stopped controller never sweeps
    `STPC_NEVER(a_stop_no_sweep, !run_reg && sweep_reg, "sweep active while stopped")
    // A stopped controller holds its pulse state
    `STPC_ASSERT(a_stop_hold_sp, !run_reg |=> $stable(setpoint_reg), "setpoint moved while stopped")
    `STPC_ASSERT(a_stop_hold_cmp, !run_reg |=> $stable(compare_reg), "compare moved while stopped")
    // A request taken from the input register shows up as a result
    `STPC_ASSERT(a_take_result, take |=> out_valid_reg, "processed request produced no result")
    // The period index moves only in frequency mode
    `STPC_ASSERT(a_period_mode, !freq_reg |=> $stable(period_reg), "period changed in pulse mode")

endmodule

FILE: sim/tb_top.sv
// Self-checking testbench for the servo tester pulse controller core, random handshakes
`timescale 1ns / 100ps

module tb_top;
    import stpc_pkg::*;

    localparam int TOP_SCALE  = 100;
    localparam int SWEEP_UNIT = 4;

    // Action codes the block must ignore
    localparam logic [2:0] ACT_RESERVED_LO = 3'd6;
    localparam logic [2:0] ACT_RESERVED_HI = 3'd7;

    // Period lengths in top-scale units, by period index
    localparam int unsigned PERIOD_LEN [4] = '{200, 80, 40, 30};

    localparam int SETTLE_CYCLES  = 6;
    localparam int RESET_CYCLES   = 11;
    localparam int CYCLE_LIMIT    = 500000;
    localparam int PHASE_REQUESTS = 280;

    // One result as the block reports it
    typedef struct packed {
        logic [15:0] compare;
        logic [15:0] top;
        logic [1:0]  period;
        logic        freq_mode;
        logic        sweeping;
        logic [7:0]  sweep_step;
        logic        active;
    } pwm_report_t;

    // Register set, in write order; the step limit uses the low byte only
    typedef struct packed {
        logic [15:0] pulse_min;
        logic [15:0] pulse_max;
        logic [15:0] pulse_centre;
        logic [15:0] sweep_low;
        logic [15:0] sweep_high;
        logic [15:0] fine_step;
        logic [15:0] coarse_unit;
        logic [15:0] step_limit;
    } limits_t;

    logic        clk;
    logic        rst_n      = 1'b0;
    logic        in_valid   = 1'b0;
    logic        in_ready;
    logic [2:0]  action     = 3'd0;
    logic [2:0]  velocity   = 3'd0;
    logic        out_valid;
    logic        out_ready  = 1'b0;
    logic [15:0] pulse_compare;
    logic [15:0] period_top;
    logic [1:0]  period_select;
    logic        frequency_mode;
    logic        sweeping;
    logic [7:0]  current_sweep_step;
    logic        active;
    logic        cfg_we     = 1'b0;
    logic [2:0]  cfg_index  = 3'd0;
    logic [15:0] cfg_data   = 16'd0;

    // Predicted controller state and register copy
    limits_t     limits;
    logic [15:0] setpoint;
    logic [15:0] compare_val;
    logic [1:0]  period_idx;
    logic        adjust_freq;
    logic        sweep_on;
    logic [7:0]  sweep_step;
    dir_t        sweep_dir;
    logic        running;

    // Reports owed by the block, oldest first
    pwm_report_t pwm_reports [$];
    pwm_report_t owed;

    int mismatch_count = 0;
    int cycle_count    = 0;
    int send_burst     = 0;
    int ready_burst    = 0;
    int ready_hold     = 0;

    servo_tester_pulse_controller_core #(
        .TOP_SCALE  (TOP_SCALE),
        .SWEEP_UNIT (SWEEP_UNIT)
    ) dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .action             (action),
        .velocity           (velocity),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .pulse_compare      (pulse_compare),
        .period_top         (period_top),
        .period_select      (period_select),
        .frequency_mode     (frequency_mode),
        .sweeping           (sweeping),
        .current_sweep_step (current_sweep_step),
        .active             (active),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Draw a wait in cycles; now and then start a run of back-to-back transfers
    function automatic int draw_wait(inout int burst_left);
        if (burst_left > 0)
        begin
            burst_left--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
        begin
            burst_left = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, 14);
    endfunction

    // Right or left key: period index, sweep step or pulse setpoint, by mode
    function automatic void move_by_key(input logic up, input int unsigned stride);
        int unsigned t;
        if (adjust_freq)
        begin
            if (up)
            begin
                if (period_idx < 2'd3)
                    period_idx++;
            end
            else if (period_idx > 2'd0)
            begin
                period_idx--;
            end
        end
        else if (sweep_on)
        begin
            if (up)
            begin
                // Saturate at the step limit
                t = 32'(sweep_step) + stride;
                if (t > 32'(limits.step_limit[7:0]))
                    t = 32'(limits.step_limit[7:0]);
                sweep_step = 8'(t);
            end
            else if (stride >= 32'(sweep_step))
            begin
                sweep_step = 8'd1;
            end
            else
            begin
                sweep_step = 8'(32'(sweep_step) - stride);
            end
        end
        else
        begin
            // Clamp to the pulse window at full width, then load the compare too
            t = 32'(setpoint);
            if (up)
            begin
                t = t + stride;
                if (t > 32'(limits.pulse_max))
                    t = 32'(limits.pulse_max);
            end
            else if (stride > t || t - stride < 32'(limits.pulse_min))
            begin
                t = 32'(limits.pulse_min);
            end
            else
            begin
                t = t - stride;
            end
            setpoint    = 16'(t);
            compare_val = setpoint;
        end
    endfunction

    // Advance the controller by one request and report the resulting state
    function automatic pwm_report_t step_controller(input logic [2:0] act,
                                                    input logic [2:0] vel);
        int unsigned stride;
        int unsigned cur;
        int unsigned top;
        pwm_report_t rep;
        if (running)
        begin
            if (sweep_on)
                stride = (vel > 3'd1) ? (32'(vel) - 1) * SWEEP_UNIT : 32'(vel);
            else
                stride = (vel > 3'd1) ? (32'(vel) - 1) * 32'(limits.coarse_unit)
                                      : 32'(limits.fine_step);
            case (act)
                ACT_SHORT:
                    adjust_freq = ~adjust_freq;
                ACT_DOUBLE:
                begin
                    running  = 1'b0;
                    sweep_on = 1'b0;
                end
                ACT_LONG:
                begin
                    if (!adjust_freq)
                    begin
                        if (sweep_on)
                        begin
                            sweep_step = 8'd1;
                        end
                        else
                        begin
                            setpoint    = limits.pulse_centre;
                            compare_val = limits.pulse_centre;
                        end
                    end
                    else if (sweep_on)
                    begin
                        sweep_on = 1'b0;
                    end
                    else
                    begin
                        sweep_on   = 1'b1;
                        sweep_step = 8'd1;
                        sweep_dir  = DIR_FWD;
                    end
                end
                ACT_RIGHT:
                    move_by_key(1'b1, stride);
                ACT_LEFT:
                    move_by_key(1'b0, stride);
                ACT_TICK:
                begin
                    if (sweep_on)
                    begin
                        // Bounce between the turning points, no 16-bit wrap
                        cur = 32'(compare_val);
                        if (sweep_dir == DIR_FWD)
                        begin
                            cur = cur + 32'(sweep_step);
                            if (cur >= 32'(limits.sweep_high))
                            begin
                                cur       = 32'(limits.sweep_high);
                                sweep_dir = DIR_BWD;
                            end
                        end
                        else if (32'(sweep_step) >= cur
                                 || cur - 32'(sweep_step) <= 32'(limits.sweep_low))
                        begin
                            cur       = 32'(limits.sweep_low);
                            sweep_dir = DIR_FWD;
                        end
                        else
                        begin
                            cur = cur - 32'(sweep_step);
                        end
                        compare_val = 16'(cur);
                    end
                end
                default:
                    ;
            endcase
        end
        top = TOP_SCALE * PERIOD_LEN[period_idx];
        if (top > 32'hFFFF)
            top = 32'hFFFF;
        rep.compare    = compare_val;
        rep.top        = 16'(top);
        rep.period     = period_idx;
        rep.freq_mode  = adjust_freq;
        rep.sweeping   = sweep_on;
        rep.sweep_step = sweep_step;
        rep.active     = running;
        return rep;
    endfunction

    function automatic void compare_field(input string name, input int unsigned want,
                                          input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    // Drive one request from a falling edge; hold valid until the block takes it.
    // Valid stays high on return so a back-to-back request needs no drop.
    task automatic send_request(input logic [2:0] act, input logic [2:0] vel);
        int gap;
        gap = draw_wait(send_burst);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        action   <= act;
        velocity <= vel;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pwm_reports.push_back(step_controller(act, vel));
        @(negedge clk);
    endtask

    // Drop valid and hold off until every owed report has come back
    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (pwm_reports.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic drive_register(input cfg_index_t idx, input logic [15:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
    endtask

    // Write all eight registers while idle, write enable held across them
    task automatic load_limits(input limits_t lim);
        wait_for_results();
        drive_register(CFG_PULSE_MIN,    lim.pulse_min);
        drive_register(CFG_PULSE_MAX,    lim.pulse_max);
        drive_register(CFG_PULSE_CENTRE, lim.pulse_centre);
        drive_register(CFG_SWEEP_LOW,    lim.sweep_low);
        drive_register(CFG_SWEEP_HIGH,   lim.sweep_high);
        drive_register(CFG_FINE_STEP,    lim.fine_step);
        drive_register(CFG_COARSE_UNIT,  lim.coarse_unit);
        drive_register(CFG_STEP_LIMIT,   lim.step_limit);
        cfg_we <= 1'b0;
        limits = lim;
        @(negedge clk);
    endtask

    // Weighted request mix: ticks and keys dominate, mode changes often enough
    // to spend long stretches in sweep and frequency mode, no double press
    function automatic logic [2:0] draw_action();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 10)
            return ACT_SHORT;
        if (roll < 18)
            return ACT_LONG;
        if (roll < 42)
            return ACT_RIGHT;
        if (roll < 66)
            return ACT_LEFT;
        if (roll < 95)
            return ACT_TICK;
        return (roll < 97) ? ACT_RESERVED_LO : ACT_RESERVED_HI;
    endfunction

    task automatic send_random_mix(input int count);
        for (int n = 0; n < count; n++)
        begin
            // Now and then let the pipeline run dry in the middle of traffic
            if ($urandom_range(0, 99) == 0)
                wait_for_results();
            send_request(draw_action(), 3'($urandom_range(0, 7)));
        end
    endtask

    // Pulse mode keys from reset: both key speeds, recentre, ignored codes
    task automatic test_pulse_keys();
        send_request(ACT_LEFT, 3'd7);
        send_request(ACT_RIGHT, 3'd0);
        send_request(ACT_RIGHT, 3'd1);
        send_request(ACT_LONG, 3'd3);
        send_request(ACT_TICK, 3'd1);
        send_request(ACT_RESERVED_LO, 3'd2);
        send_request(ACT_RESERVED_HI, 3'd5);
    endtask

    // Frequency mode: walk the period index into both ends and past them
    task automatic test_period_keys();
        send_request(ACT_SHORT, 3'd1);
        send_request(ACT_LEFT, 3'd3);
        repeat (4) send_request(ACT_RIGHT, 3'd4);
        send_request(ACT_LEFT, 3'd6);
    endtask

    // Enter sweep, tick, adjust the step both ways, reset it, then leave sweep
    task automatic test_sweep_keys();
        send_request(ACT_LONG, 3'd2);
        send_request(ACT_TICK, 3'd0);
        send_request(ACT_TICK, 3'd7);
        send_request(ACT_SHORT, 3'd1);
        send_request(ACT_RIGHT, 3'd7);
        send_request(ACT_LEFT, 3'd0);
        send_request(ACT_LEFT, 3'd7);
        send_request(ACT_RIGHT, 3'd2);
        send_request(ACT_LONG, 3'd1);
        send_request(ACT_SHORT, 3'd1);
        send_request(ACT_LONG, 3'd4);
    endtask

    // Random traffic on the reset register values
    task automatic test_random_traffic();
        send_random_mix(300);
    endtask

    // Random traffic under several register sets, extremes included
    task automatic test_register_sets();
        limits_t lim;
        // Widest window, largest steps: overflow and underflow of the adders
        lim = '{16'd0, 16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd255};
        load_limits(lim);
        send_random_mix(PHASE_REQUESTS);
        // Inverted windows, zero steps, step limit of one
        lim = '{16'd3000, 16'd100, 16'd40000, 16'd2000, 16'd1000, 16'd0, 16'd0, 16'd1};
        load_limits(lim);
        send_random_mix(PHASE_REQUESTS);
        // Narrow window, small steps, junk in the step limit's upper byte
        lim = '{16'd10, 16'd300, 16'd150, 16'd50, 16'd250, 16'd1, 16'd7, 16'hA5FF};
        load_limits(lim);
        send_random_mix(PHASE_REQUESTS);
        lim.pulse_min    = 16'($urandom);
        lim.pulse_max    = 16'($urandom);
        lim.pulse_centre = 16'($urandom);
        lim.sweep_low    = 16'($urandom);
        lim.sweep_high   = 16'($urandom);
        lim.fine_step    = 16'($urandom);
        lim.coarse_unit  = 16'($urandom_range(0, 2000));
        lim.step_limit   = {8'($urandom), 8'($urandom_range(1, 255))};
        load_limits(lim);
        send_random_mix(PHASE_REQUESTS);
        // Back to the reset values
        lim = '{PULSE_MIN_RST, PULSE_MAX_RST, PULSE_CENTRE_RST, SWEEP_LOW_RST,
                SWEEP_HIGH_RST, FINE_STEP_RST, COARSE_UNIT_RST, {8'd0, STEP_LIMIT_RST}};
        load_limits(lim);
        send_random_mix(PHASE_REQUESTS);
    endtask

    // Double press stops the block for good; later requests only report state
    task automatic test_stop_press();
        send_request(ACT_DOUBLE, 3'd3);
        repeat (24) send_request(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)));
    endtask

    // Receiver: hold ready low for the drawn stall after each result
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (ready_hold > 0)
            begin
                out_ready <= 1'b0;
                ready_hold--;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // Check every accepted result against the oldest owed report
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pwm_reports.size() == 0)
            begin
                $error("result arrived with no request outstanding");
                mismatch_count++;
            end
            else
            begin
                owed = pwm_reports.pop_front();
                compare_field("pulse_compare", owed.compare, pulse_compare);
                compare_field("period_top", owed.top, period_top);
                compare_field("period_select", owed.period, period_select);
                compare_field("frequency_mode", owed.freq_mode, frequency_mode);
                compare_field("sweeping", owed.sweeping, sweeping);
                compare_field("current_sweep_step", owed.sweep_step, current_sweep_step);
                compare_field("active", owed.active, active);
            end
            ready_hold = draw_wait(ready_burst);
        end
    end

    // Watchdog on the whole run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("servo_tester_pulse_controller_core verification failed");
            $finish;
        end
    end

    initial
    begin
        // Predictor starts from the reset state
        limits = '{PULSE_MIN_RST, PULSE_MAX_RST, PULSE_CENTRE_RST, SWEEP_LOW_RST,
                   SWEEP_HIGH_RST, FINE_STEP_RST, COARSE_UNIT_RST, {8'd0, STEP_LIMIT_RST}};
        setpoint    = PULSE_CENTRE_RST;
        compare_val = PULSE_CENTRE_RST;
        period_idx  = 2'd0;
        adjust_freq = 1'b0;
        sweep_on    = 1'b0;
        sweep_step  = 8'd0;
        sweep_dir   = DIR_NONE;
        running     = 1'b1;

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_pulse_keys();
        test_period_keys();
        test_sweep_keys();
        test_random_traffic();
        test_register_sets();
        test_stop_press();

        // Drain, then give the pipeline time to show any stray result
        wait_for_results();
        if (mismatch_count == 0 && pwm_reports.size() == 0)
            $display("servo_tester_pulse_controller_core verification clean");
        else
            $display("servo_tester_pulse_controller_core verification failed");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl
rtl/stpc_pkg.sv
rtl/servo_tester_pulse_controller_core.sv
sim/tb_top.sv
